// ===== hdl/bes_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bes_pkg
// Shared types, constants and the address filter of the beacon element scan.
// ---------------------------------------------------------------------------
package bes_pkg;

   localparam int unsigned SsidMaxLen = 32;

   localparam logic [7:0]  TagSsid    = 8'h00;
   localparam logic [7:0]  TagRsn     = 8'h30;
   localparam logic [7:0]  TagVendor  = 8'hdd;
   localparam logic [47:0] WpaPattern = 48'h0050f2010100;
   localparam logic [2:0]  EncUnknown = 3'd4;

   // three-octet prefixes that drop a frame at any octet boundary
   localparam logic [23:0] PfxIpv4Mcast = 24'h01005e;
   localparam logic [23:0] PfxIpv6Node  = 24'h3333ff;
   localparam logic [23:0] PfxIpv6Mcast = 24'h333300;
   localparam logic [47:0] AddrStp      = 48'h0180c2000000;
   localparam logic [47:0] AddrZero     = 48'h000000000000;
   localparam logic [47:0] AddrBcast    = 48'hffffffffffff;

   typedef struct packed {
      logic       take;
      logic       clear;
      logic       load_hidden;
      logic       load_byte;
      logic       rd_en;
      logic [5:0] index;
   } cmd_type;

   typedef struct packed {
      logic filtered;
      logic hidden;
      logic out_last;
   } status_type;

   function automatic logic bssid_filtered(input logic [47:0] b);
      logic [23:0] w;
      logic        hit;
      hit = 1'b0;
      for (int p = 0; p < 4; p++) begin
         w = b[47 - 8 * p -: 24];
         if (w == PfxIpv4Mcast || w == PfxIpv6Node || w == PfxIpv6Mcast) begin
            hit = 1'b1;
         end
      end
      if (b == AddrStp || b == AddrZero || b == AddrBcast) begin
         hit = 1'b1;
      end
      return hit;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/bes_channels.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bes_channels
// Valid/ready channels for body bytes in and SSID report items out.
// ---------------------------------------------------------------------------
interface bes_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  body_byte;
   logic        frame_end;
   logic [47:0] bssid;

   modport source (output valid, output body_byte, output frame_end, output bssid,
                   input ready);
   modport sink   (input valid, input body_byte, input frame_end, input bssid,
                   output ready);
endinterface

interface bes_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] enc_class;
   logic       hidden;
   logic [5:0] ssid_length;
   logic [7:0] ssid_byte;
   logic [4:0] byte_index;
   logic       run_last;

   modport source (output valid, output enc_class, output hidden, output ssid_length,
                   output ssid_byte, output byte_index, output run_last, input ready);
   modport sink   (input valid, input enc_class, input hidden, input ssid_length,
                   input ssid_byte, input byte_index, input run_last, output ready);
endinterface
`default_nettype wire

// ===== hdl/beacon_element_scan.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// beacon_element_scan
// Parses beacon information elements and reports SSID and encryption class.
// ---------------------------------------------------------------------------
// body bytes: one transaction per cycle while no frame is being decided or reported
// frame end to first result: decide state, registered store read, result register
// a hidden report skips the store read and is loaded in the decide state
// each further SSID byte: once the item is taken, a store read, then the result register
// a filtered frame is cleared in the decide state and gives no result
// reset is synchronous and clears all parser and sequencer state, no sweep
module beacon_element_scan #(
   parameter int unsigned SSID_BYTES = 32
) (
   input  wire logic  clock,
   input  wire logic  reset,
   bes_req_if.sink    req_bus,
   bes_rsp_if.source  rsp_bus
);

   bes_pkg::cmd_type    cmd;
   bes_pkg::status_type status;

   bes_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_frame_end (req_bus.frame_end),
      .req_ready     (req_bus.ready),
      .rsp_valid     (rsp_bus.valid),
      .rsp_ready     (rsp_bus.ready),
      .status        (status),
      .cmd           (cmd)
   );

   bes_dpath #(
      .SSID_BYTES (SSID_BYTES)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .body_byte   (req_bus.body_byte),
      .frame_end   (req_bus.frame_end),
      .bssid       (req_bus.bssid),
      .status      (status),
      .enc_class   (rsp_bus.enc_class),
      .hidden      (rsp_bus.hidden),
      .ssid_length (rsp_bus.ssid_length),
      .ssid_byte   (rsp_bus.ssid_byte),
      .byte_index  (rsp_bus.byte_index),
      .run_last    (rsp_bus.run_last)
   );

endmodule
`default_nettype wire

// ===== hdl/bes_dpath.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bes_dpath
// Element parser registers, SSID store and the result register.
// ---------------------------------------------------------------------------
module bes_dpath #(
   parameter int unsigned SSID_BYTES = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire bes_pkg::cmd_type    cmd,
   input  wire logic [7:0]          body_byte,
   input  wire logic                frame_end,
   input  wire logic [47:0]         bssid,
   output bes_pkg::status_type      status,
   output logic [2:0]               enc_class,
   output logic                     hidden,
   output logic [5:0]               ssid_length,
   output logic [7:0]               ssid_byte,
   output logic [4:0]               byte_index,
   output logic                     run_last
);

   localparam int unsigned AddrW = (SSID_BYTES > 1) ? $clog2(SSID_BYTES) : 1;
   localparam int unsigned Limit =
      (SSID_BYTES < bes_pkg::SsidMaxLen) ? SSID_BYTES : bes_pkg::SsidMaxLen;

   typedef enum logic [1:0] {PH_TAG, PH_LEN, PH_BODY} phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  tag_ff, tag_in;
   logic [7:0]  remaining_ff, remaining_in;
   logic [7:0]  offset_ff, offset_in;
   logic [47:0] window_ff, window_in;
   logic        found_ff, found_in;
   logic [2:0]  sum_ff, sum_in;
   logic [7:0]  count_ff, count_in;
   logic        printable_ff, printable_in;
   logic        filtered_ff;
   logic [1:0]  enc_inc;
   logic [3:0]  enc_total;
   logic        wr_en;

   logic [7:0]  ssid_mem [SSID_BYTES];
   logic [7:0]  rd_data_ff;

   logic [2:0]  enc_ff;
   logic        hidden_ff;
   logic [5:0]  len_ff;
   logic [7:0]  byte_ff;
   logic [4:0]  index_ff;
   logic        last_ff;

   always_comb begin
      phase_in     = phase_ff;
      tag_in       = tag_ff;
      remaining_in = remaining_ff;
      offset_in    = offset_ff;
      window_in    = window_ff;
      found_in     = found_ff;
      count_in     = count_ff;
      printable_in = printable_ff;
      enc_inc      = 2'd0;
      wr_en        = 1'b0;
      if (cmd.take) begin
         unique case (phase_ff)
            PH_TAG: begin
               tag_in    = body_byte;
               offset_in = 8'd0;
               if (body_byte == bes_pkg::TagSsid) begin
                  count_in     = 8'd0;
                  printable_in = 1'b1;
               end else if (body_byte == bes_pkg::TagRsn) begin
                  enc_inc = 2'd2;
               end else if (body_byte == bes_pkg::TagVendor) begin
                  window_in = 48'd0;
                  found_in  = 1'b0;
               end
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               remaining_in = body_byte;
               phase_in     = (body_byte == 8'd0) ? PH_TAG : PH_BODY;
            end
            PH_BODY: begin
               if (tag_ff == bes_pkg::TagSsid) begin
                  wr_en = (count_ff < 8'(SSID_BYTES));
                  if (body_byte < 8'd32 || body_byte > 8'd127) begin
                     printable_in = 1'b0;
                  end
                  if (count_ff != 8'hff) begin
                     count_in = count_ff + 8'd1;
                  end
               end else if (tag_ff == bes_pkg::TagVendor) begin
                  window_in = {window_ff[39:0], body_byte};
                  if (offset_ff != 8'hff) begin
                     offset_in = offset_ff + 8'd1;
                  end
                  // the pattern opens with a zero octet, so wait for six bytes
                  if (!found_ff && offset_in >= 8'd6 && window_in == bes_pkg::WpaPattern) begin
                     found_in = 1'b1;
                     enc_inc  = 2'd1;
                  end
               end
               remaining_in = remaining_ff - 8'd1;
               if (remaining_in == 8'd0) begin
                  phase_in = PH_TAG;
               end
            end
            default: begin
               phase_in = PH_TAG;
            end
         endcase
      end
      enc_total = {1'b0, sum_ff} + {2'b00, enc_inc};
      sum_in    = (enc_total > {1'b0, bes_pkg::EncUnknown}) ? bes_pkg::EncUnknown
                                                             : enc_total[2:0];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         phase_ff     <= PH_TAG;
         tag_ff       <= 8'd0;
         remaining_ff <= 8'd0;
         offset_ff    <= 8'd0;
         window_ff    <= 48'd0;
         found_ff     <= 1'b0;
         sum_ff       <= 3'd0;
         count_ff     <= 8'd0;
         printable_ff <= 1'b1;
         filtered_ff  <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         tag_ff       <= tag_in;
         remaining_ff <= remaining_in;
         offset_ff    <= offset_in;
         window_ff    <= window_in;
         found_ff     <= found_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         printable_ff <= printable_in;
         if (cmd.take && frame_end) begin
            filtered_ff <= bes_pkg::bssid_filtered(bssid);
         end
      end
   end

   // ssid store: one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ssid_mem[count_ff[AddrW-1:0]] <= body_byte;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= ssid_mem[cmd.index[AddrW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= 1'b0;
      end else if (cmd.load_hidden) begin
         enc_ff    <= sum_ff;
         hidden_ff <= 1'b1;
         len_ff    <= 6'd0;
         byte_ff   <= 8'd0;
         index_ff  <= 5'd0;
         last_ff   <= 1'b1;
      end else if (cmd.load_byte) begin
         enc_ff    <= sum_ff;
         hidden_ff <= 1'b0;
         len_ff    <= count_ff[5:0];
         byte_ff   <= rd_data_ff;
         index_ff  <= cmd.index[4:0];
         last_ff   <= ({2'b00, cmd.index} + 8'd1 == count_ff);
      end
   end

   assign status.filtered = filtered_ff;
   assign status.hidden   = (count_ff == 8'd0) || (count_ff > 8'(Limit)) || !printable_ff;
   assign status.out_last = last_ff;

   assign enc_class   = enc_ff;
   assign hidden      = hidden_ff;
   assign ssid_length = len_ff;
   assign ssid_byte   = byte_ff;
   assign byte_index  = index_ff;
   assign run_last    = last_ff;

endmodule
`default_nettype wire

// ===== hdl/bes_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bes_ctrl
// Sequencer: takes body bytes, then sends a hidden report or walks the store.
// ---------------------------------------------------------------------------
module bes_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_frame_end,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire bes_pkg::status_type status,
   output bes_pkg::cmd_type         cmd
);

   typedef enum logic [1:0] {S_TAKE, S_DECIDE, S_READ, S_SEND} state_type;

   state_type  state_ff;
   logic       rsp_valid_ff;
   logic [5:0] idx_ff;

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_TAKE: begin
            cmd.take = req_valid;
         end
         S_DECIDE: begin
            priority if (status.filtered) begin
               cmd.clear = 1'b1;
            end else if (status.hidden) begin
               cmd.load_hidden = 1'b1;
            end else begin
               cmd.rd_en = 1'b1;
               cmd.index = 6'd0;
            end
         end
         S_READ: begin
            cmd.load_byte = 1'b1;
            cmd.index     = idx_ff;
         end
         S_SEND: begin
            if (rsp_ready) begin
               if (status.out_last) begin
                  cmd.clear = 1'b1;
               end else begin
                  cmd.rd_en = 1'b1;
                  cmd.index = idx_ff + 6'd1;
               end
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_TAKE;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 6'd0;
      end else begin
         unique case (state_ff)
            S_TAKE: begin
               if (req_valid && req_frame_end) begin
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               priority if (status.filtered) begin
                  state_ff <= S_TAKE;
               end else if (status.hidden) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_SEND;
               end else begin
                  idx_ff   <= 6'd0;
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_SEND;
            end
            S_SEND: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (status.out_last) begin
                     state_ff <= S_TAKE;
                  end else begin
                     idx_ff   <= idx_ff + 6'd1;
                     state_ff <= S_READ;
                  end
               end
            end
            default: begin
               state_ff <= S_TAKE;
            end
         endcase
      end
   end

   assign req_ready = (state_ff == S_TAKE);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== hdl/bes_checker.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bes_checker
// Port-level checks of the beacon element scan, bound to the top level.
// ---------------------------------------------------------------------------
module bes_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       req_frame_end,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_enc_class,
   input wire logic       rsp_hidden,
   input wire logic [5:0] rsp_ssid_length,
   input wire logic [7:0] rsp_ssid_byte,
   input wire logic [4:0] rsp_byte_index,
   input wire logic       rsp_run_last
);

   // a stalled result transaction keeps its SSID byte, byte index and run-last flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ssid_byte)
         && $stable(rsp_byte_index) && $stable(rsp_run_last))
      else $error("result transaction changed while stalled");

   // input is held off while a report is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input ready while a result is pending");

   a_frame_end_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_frame_end |=> !req_ready)
      else $error("input taken right after frame end");

   a_hidden_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hidden |-> rsp_run_last && rsp_ssid_length == 6'd0
         && rsp_ssid_byte == 8'd0 && rsp_enc_class <= 3'd4)
      else $error("malformed hidden result");

   a_run_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hidden |-> rsp_ssid_length != 6'd0
         && {1'b0, rsp_byte_index} < rsp_ssid_length
         && (rsp_run_last == ({1'b0, rsp_byte_index} + 6'd1 == rsp_ssid_length)))
      else $error("SSID run item out of range");

endmodule

bind beacon_element_scan bes_checker u_bes_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .req_frame_end   (req_bus.frame_end),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_enc_class   (rsp_bus.enc_class),
   .rsp_hidden      (rsp_bus.hidden),
   .rsp_ssid_length (rsp_bus.ssid_length),
   .rsp_ssid_byte   (rsp_bus.ssid_byte),
   .rsp_byte_index  (rsp_bus.byte_index),
   .rsp_run_last    (rsp_bus.run_last)
);
`default_nettype wire
